// ===== hw/rtl/bzc_pkg.sv =====
package bzc_pkg;

  localparam int unsigned DutyW = 16;
  localparam int unsigned PhaseN = 3;

  localparam logic [DutyW-1:0] DUTY_RESET = 16'd200;

  // Port that raised the comparator event
  localparam logic PORT_Z13 = 1'b0;
  localparam logic PORT_Z2  = 1'b1;

  // Z1/Z3 change patterns (bit0 = Z1, bit1 = Z3)
  localparam logic [1:0] DIFF_Z1 = 2'b01;
  localparam logic [1:0] DIFF_Z3 = 2'b10;

  typedef enum logic [2:0] {
    STEP_1 = 3'd1,
    STEP_2 = 3'd2,
    STEP_3 = 3'd3,
    STEP_4 = 3'd4,
    STEP_5 = 3'd5,
    STEP_6 = 3'd6
  } step_t;

  typedef struct packed {
    logic z1_level;
    logic z2_level;
    logic z3_level;
    logic event_port;
  } item_t;

  typedef struct packed {
    logic [PhaseN-1:0] hi;
    logic [PhaseN-1:0] lo;
  } masks_t;

  typedef struct packed {
    logic [PhaseN-1:0] high_pwm_mask;
    logic [PhaseN-1:0] low_on_mask;
    logic [DutyW-1:0]  duty_out;
    logic [2:0]        step_now;
    logic              advanced;
  } result_t;

  // Switch pattern applied when the given step commutates
  function automatic masks_t commutate(step_t s, masks_t m);
    masks_t r;
    r = m;
    unique case (s)
      STEP_1: begin r.hi[2] = 1'b0; r.lo[2] = 1'b0; r.lo[1] = 1'b1; end
      STEP_2: begin r.hi[0] = 1'b0; r.lo[0] = 1'b0; r.hi[2] = 1'b1; end
      STEP_3: begin r.hi[1] = 1'b0; r.lo[1] = 1'b0; r.lo[0] = 1'b1; end
      STEP_4: begin r.hi[2] = 1'b0; r.lo[2] = 1'b0; r.hi[1] = 1'b1; end
      STEP_5: begin r.hi[0] = 1'b0; r.lo[0] = 1'b0; r.lo[2] = 1'b1; end
      STEP_6: begin r.hi[1] = 1'b0; r.lo[1] = 1'b0; r.hi[0] = 1'b1; end
      default: r = m;
    endcase
    return r;
  endfunction

  function automatic step_t next_step(step_t s);
    step_t n;
    unique case (s)
      STEP_1:  n = STEP_2;
      STEP_2:  n = STEP_3;
      STEP_3:  n = STEP_4;
      STEP_4:  n = STEP_5;
      STEP_5:  n = STEP_6;
      STEP_6:  n = STEP_1;
      default: n = STEP_1;
    endcase
    return n;
  endfunction

endpackage

// ===== hw/rtl/bzc_if.sv =====
interface bzc_in_if;
  logic valid;
  logic ready;
  logic z1_level;
  logic z2_level;
  logic z3_level;
  logic event_port;

  modport source (output valid, output z1_level, output z2_level, output z3_level,
                  output event_port, input ready);
  modport sink (input valid, input z1_level, input z2_level, input z3_level,
                input event_port, output ready);
endinterface

interface bzc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  high_pwm_mask;
  logic [2:0]  low_on_mask;
  logic [15:0] duty_out;
  logic [2:0]  step_now;
  logic        advanced;

  modport source (output valid, output high_pwm_mask, output low_on_mask,
                  output duty_out, output step_now, output advanced, input ready);
  modport sink (input valid, input high_pwm_mask, input low_on_mask,
                input duty_out, input step_now, input advanced, output ready);
endinterface

interface bzc_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] pwm_duty;

  modport source (output valid, output pwm_duty, input ready);
  modport sink (input valid, input pwm_duty, output ready);
endinterface

// ===== hw/rtl/bzc_in_stage.sv =====
module bzc_in_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  bzc_pkg::item_t in_item,
  output logic          item_vld,
  input  logic          item_take,
  output bzc_pkg::item_t item
);
  import bzc_pkg::*;

  logic  vld_r, vld_nxt;
  item_t item_r;

  // take a new item when the slot is empty or drains this cycle
  assign in_ready = !vld_r || item_take;
  assign vld_nxt  = (in_valid && in_ready) || (vld_r && !item_take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign item_vld = vld_r;
  assign item     = item_r;

endmodule

// ===== hw/rtl/bzc_commutator.sv =====
module bzc_commutator (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     item_vld,
  output logic                     item_take,
  input  bzc_pkg::item_t           item,
  input  logic [bzc_pkg::DutyW-1:0] duty,
  output logic                     res_vld,
  input  logic                     res_ready,
  output bzc_pkg::result_t         res
);
  import bzc_pkg::*;

  step_t     step_r, step_nxt;
  logic [1:0] prev_r, prev_nxt;
  masks_t    masks_r, masks_nxt;
  logic      res_vld_r, res_vld_nxt;
  result_t   res_r, res_nxt;

  logic [1:0] cur;
  logic [1:0] diff;
  logic       want_ok;
  step_t      want;
  logic       hit;

  assign item_take = item_vld && (!res_vld_r || res_ready);

  always_comb begin
    cur     = {item.z3_level, item.z1_level};
    diff    = prev_r ^ cur;
    want_ok = 1'b0;
    want    = STEP_1;
    if (item.event_port == PORT_Z13) begin
      if (diff == DIFF_Z1) begin
        want_ok = 1'b1;
        want    = item.z1_level ? STEP_6 : STEP_3;
      end else if (diff == DIFF_Z3) begin
        want_ok = 1'b1;
        want    = item.z3_level ? STEP_2 : STEP_5;
      end
    end else begin
      want_ok = 1'b1;
      want    = item.z2_level ? STEP_4 : STEP_1;
    end
    hit = want_ok && (step_r == want);

    step_nxt  = step_r;
    prev_nxt  = prev_r;
    masks_nxt = masks_r;
    if (item_take) begin
      if (item.event_port == PORT_Z13) begin
        prev_nxt = cur;
      end
      if (hit) begin
        masks_nxt = commutate(step_r, masks_r);
        step_nxt  = next_step(step_r);
      end
    end

    res_nxt.high_pwm_mask = masks_nxt.hi;
    res_nxt.low_on_mask   = masks_nxt.lo;
    res_nxt.duty_out      = duty;
    res_nxt.step_now      = step_nxt;
    res_nxt.advanced      = hit;

    res_vld_nxt = item_take || (res_vld_r && !res_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r    <= STEP_1;
      prev_r    <= 2'b00;
      masks_r   <= '0;
      res_vld_r <= 1'b0;
    end else begin
      step_r    <= step_nxt;
      prev_r    <= prev_nxt;
      masks_r   <= masks_nxt;
      res_vld_r <= res_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      res_r <= res_nxt;
    end
  end

  assign res_vld = res_vld_r;
  assign res     = res_r;

endmodule

// ===== hw/rtl/bldc_zero_cross_commutator.sv =====
// Six-step sensorless BLDC commutator driven by back-EMF comparator events.
//
// in_ch  : one transfer per comparator event: the three sampled comparator
//          levels and the port that raised it (Z1/Z3 port or Z2 port).
// out_ch : one transfer per event: high-side PWM mask, low-side on mask,
//          the PWM compare value, the step expected next and a flag that
//          tells whether this event commutated.
// cfg_ch : write of the PWM compare value; always ready. Write it only
//          while no event is in flight.
//
// An event passes two registers: the input register, then the step/edge
// decode and mask update into the result register. Throughput is one
// event per cycle while the receiver takes each result, set by the state
// update; the input slot refills while a result waits to be taken.
// If the receiver stalls, the result register holds, then the input
// register fills and in_ch.ready drops until the result is taken.
// Reset (rst_n low, synchronous) returns to step 1, clears the stored
// Z1/Z3 levels and all switch masks, and loads a compare value of 200.
module bldc_zero_cross_commutator (
  input logic         clk,
  input logic         rst_n,
  bzc_in_if.sink      in_ch,
  bzc_out_if.source   out_ch,
  bzc_cfg_if.sink     cfg_ch
);
  import bzc_pkg::*;

  logic [DutyW-1:0] duty_r, duty_nxt;
  item_t            in_item;
  item_t            item;
  logic             item_vld;
  logic             item_take;
  result_t          res;

  // compare value register; writes always complete
  assign cfg_ch.ready = 1'b1;
  assign duty_nxt     = (cfg_ch.valid && cfg_ch.ready) ? cfg_ch.pwm_duty : duty_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      duty_r <= DUTY_RESET;
    end else begin
      duty_r <= duty_nxt;
    end
  end

  // pack the incoming event
  assign in_item.z1_level   = in_ch.z1_level;
  assign in_item.z2_level   = in_ch.z2_level;
  assign in_item.z3_level   = in_ch.z3_level;
  assign in_item.event_port = in_ch.event_port;

  bzc_in_stage u_in_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_item   (in_item),
    .item_vld  (item_vld),
    .item_take (item_take),
    .item      (item)
  );

  // edge decode, step check and mask update feed the result register
  bzc_commutator u_commutator (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_vld  (item_vld),
    .item_take (item_take),
    .item      (item),
    .duty      (duty_r),
    .res_vld   (out_ch.valid),
    .res_ready (out_ch.ready),
    .res       (res)
  );

  assign out_ch.high_pwm_mask = res.high_pwm_mask;
  assign out_ch.low_on_mask   = res.low_on_mask;
  assign out_ch.duty_out      = res.duty_out;
  assign out_ch.step_now      = res.step_now;
  assign out_ch.advanced      = res.advanced;

endmodule

// ===== dv/tb_bldc_zero_cross_commutator.sv =====
`timescale 1ns / 100ps

module tb_bldc_zero_cross_commutator;
  import bzc_pkg::*;

  // Longest deliberate receiver hold-off, and the no-transfer limit of the
  // watchdog, which is set well above it and above any random idle run.
  localparam int unsigned HoldOffCycles = 200;
  localparam int unsigned StallLimit    = 3000;
  // Input register plus result register, with some margin.
  localparam int unsigned SettleCycles  = 4;
  localparam int unsigned PhaseEvents   = 160;

  logic clk;
  logic rst_n;

  bzc_in_if  in_ch ();
  bzc_out_if out_ch ();
  bzc_cfg_if cfg_ch ();

  bldc_zero_cross_commutator dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Predicted commutator state: step expected next, last Z1/Z3 levels
  // (bit0 = Z1, bit1 = Z3), switch masks and the compare value.
  step_t       cur_step;
  logic [1:0]  last_z13;
  logic [2:0]  hi_pwm;
  logic [2:0]  lo_on;
  logic [15:0] duty_reg;

  // Switch states the block must report, oldest first.
  result_t pending_switch_states[$];

  int idle_pct;
  int stall_pct;
  int holdoff_req;
  int idle_count;
  int fail_count;
  int events_sent;
  int results_checked;
  int commutations;
  int duty_writes;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Work out the result of one accepted event and queue it.
  task automatic record_event(item_t ev);
    logic [1:0] now_z13;
    logic [1:0] changed;
    logic       has_edge;
    logic       fired;
    step_t      edge_step;
    logic [2:0] off_phase;
    logic [2:0] on_phase;
    result_t    r;
    has_edge  = 1'b0;
    edge_step = STEP_1;
    if (ev.event_port == PORT_Z13) begin
      now_z13 = {ev.z3_level, ev.z1_level};
      changed = now_z13 ^ last_z13;
      // Only a single-comparator change is an edge; the stored levels follow
      // the port whatever happens.
      if (changed == DIFF_Z1) begin
        has_edge  = 1'b1;
        edge_step = ev.z1_level ? STEP_6 : STEP_3;
      end else if (changed == DIFF_Z3) begin
        has_edge  = 1'b1;
        edge_step = ev.z3_level ? STEP_2 : STEP_5;
      end
      last_z13 = now_z13;
    end else begin
      has_edge  = 1'b1;
      edge_step = ev.z2_level ? STEP_4 : STEP_1;
    end
    fired = has_edge && (edge_step == cur_step);
    if (fired) begin
      // Each step floats one phase (both switches off) and closes one
      // switch: a low side on odd steps, a PWM high side on even steps.
      case (cur_step)
        STEP_1:  begin off_phase = 3'b100; on_phase = 3'b010; end
        STEP_2:  begin off_phase = 3'b001; on_phase = 3'b100; end
        STEP_3:  begin off_phase = 3'b010; on_phase = 3'b001; end
        STEP_4:  begin off_phase = 3'b100; on_phase = 3'b010; end
        STEP_5:  begin off_phase = 3'b001; on_phase = 3'b100; end
        default: begin off_phase = 3'b010; on_phase = 3'b001; end
      endcase
      hi_pwm = hi_pwm & ~off_phase;
      lo_on  = lo_on & ~off_phase;
      if (cur_step inside {STEP_2, STEP_4, STEP_6}) begin
        hi_pwm = hi_pwm | on_phase;
      end else begin
        lo_on = lo_on | on_phase;
      end
      cur_step = (cur_step == STEP_6) ? STEP_1 : step_t'(cur_step + 3'd1);
      commutations++;
    end
    r.high_pwm_mask = hi_pwm;
    r.low_on_mask   = lo_on;
    r.duty_out      = duty_reg;
    r.step_now      = cur_step;
    r.advanced      = fired;
    pending_switch_states.push_back(r);
    events_sent++;
  endtask

  function automatic item_t mk_event(logic port, logic z1, logic z2, logic z3);
    item_t ev;
    ev.z1_level   = z1;
    ev.z2_level   = z2;
    ev.z3_level   = z3;
    ev.event_port = port;
    return ev;
  endfunction

  // Event a spinning motor would raise next. Toggling the awaited comparator
  // either gives the matching edge or first puts it on the far side of it.
  // Levels the block ignores are random.
  function automatic item_t next_motor_event();
    item_t ev;
    ev = item_t'($urandom_range(15));
    case (cur_step)
      STEP_1, STEP_4: begin
        ev.event_port = PORT_Z2;
        ev.z2_level   = (cur_step == STEP_4);
      end
      STEP_2, STEP_5: begin
        ev.event_port = PORT_Z13;
        ev.z1_level   = last_z13[0];
        ev.z3_level   = ~last_z13[1];
      end
      default: begin
        ev.event_port = PORT_Z13;
        ev.z1_level   = ~last_z13[0];
        ev.z3_level   = last_z13[1];
      end
    endcase
    return ev;
  endfunction

  // Mostly clean rotation, the rest noise and broken sequences.
  function automatic item_t pick_event();
    if ($urandom_range(99) < 70) begin
      return next_motor_event();
    end
    return item_t'($urandom_range(15));
  endfunction

  // Offer one event; keep valid high afterwards so back-to-back transfers
  // need no second assignment in a time step.
  task automatic send_event(item_t ev);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid      = 1'b1;
    in_ch.z1_level   = ev.z1_level;
    in_ch.z2_level   = ev.z2_level;
    in_ch.z3_level   = ev.z3_level;
    in_ch.event_port = ev.event_port;
    do @(posedge clk); while (!in_ch.ready);
    record_event(ev);
  endtask

  // Drop valid and wait until every result is in and the pipeline is empty.
  task automatic wait_until_idle();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending_switch_states.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_duty(logic [15:0] value);
    wait_until_idle();
    @(negedge clk);
    cfg_ch.valid    = 1'b1;
    cfg_ch.pwm_duty = value;
    do @(posedge clk); while (!cfg_ch.ready);
    duty_reg = value;
    duty_writes++;
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // Walk a full electrical turn at the reset compare value, with the
  // out-of-turn, both-changed and nothing-changed cases in between.
  task automatic test_directed_walk();
    idle_pct  = 0;
    stall_pct = 0;
    send_event(mk_event(PORT_Z13, 1'b0, 1'b1, 1'b0)); // neither Z1 nor Z3 moved
    send_event(mk_event(PORT_Z13, 1'b1, 1'b0, 1'b1)); // both moved at once
    send_event(mk_event(PORT_Z2,  1'b0, 1'b1, 1'b0)); // Z2 high, low awaited
    send_event(mk_event(PORT_Z2,  1'b1, 1'b0, 1'b0)); // step 1
    send_event(mk_event(PORT_Z13, 1'b1, 1'b0, 1'b0)); // Z3 falls out of turn
    send_event(mk_event(PORT_Z13, 1'b0, 1'b1, 1'b0)); // Z1 falls out of turn
    send_event(mk_event(PORT_Z13, 1'b0, 1'b0, 1'b1)); // step 2
    send_event(mk_event(PORT_Z13, 1'b1, 1'b1, 1'b1)); // Z1 rises early
    send_event(mk_event(PORT_Z13, 1'b0, 1'b0, 1'b1)); // step 3
    send_event(mk_event(PORT_Z2,  1'b0, 1'b0, 1'b1)); // Z2 low out of turn
    send_event(mk_event(PORT_Z2,  1'b1, 1'b1, 1'b0)); // step 4
    send_event(mk_event(PORT_Z13, 1'b0, 1'b0, 1'b0)); // step 5
    send_event(mk_event(PORT_Z13, 1'b1, 1'b1, 1'b0)); // step 6, back to 1
  endtask

  task automatic test_duty_extremes();
    write_duty(16'h0000);
    repeat (5) send_event(next_motor_event());
    write_duty(16'hFFFF);
    repeat (5) send_event(next_motor_event());
  endtask

  // One random compare value per idling phase.
  task automatic test_random_phases();
    int idle_set[4];
    int stall_set[4];
    idle_set  = '{0, 51, 0, 29};
    stall_set = '{0, 0, 51, 29};
    for (int p = 0; p < 4; p++) begin
      write_duty(16'($urandom_range(65535)));
      idle_pct  = idle_set[p];
      stall_pct = stall_set[p];
      repeat (PhaseEvents) send_event(pick_event());
    end
  endtask

  // Hold the receiver off while events keep coming, so the input stalls.
  task automatic test_receiver_holdoff();
    wait_until_idle();
    idle_pct    = 0;
    stall_pct   = 0;
    holdoff_req = HoldOffCycles;
    repeat (40) send_event(pick_event());
  endtask

  // Receiver: random stalls, or a long hold-off counted here on request.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (holdoff_req > 0) begin
        out_ch.ready = 1'b0;
        repeat (holdoff_req - 1) @(negedge clk);
        holdoff_req = 0;
      end else begin
        out_ch.ready = ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Compare each result transfer with the oldest expectation.
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_checked++;
      if (pending_switch_states.size() == 0) begin
        $error("result transfer with nothing outstanding");
        fail_count++;
      end else begin
        want = pending_switch_states.pop_front();
        if (out_ch.high_pwm_mask !== want.high_pwm_mask) begin
          $error("high_pwm_mask: expected %0d, got %0d",
                 want.high_pwm_mask, out_ch.high_pwm_mask);
          fail_count++;
        end
        if (out_ch.low_on_mask !== want.low_on_mask) begin
          $error("low_on_mask: expected %0d, got %0d", want.low_on_mask, out_ch.low_on_mask);
          fail_count++;
        end
        if (out_ch.duty_out !== want.duty_out) begin
          $error("duty_out: expected %0d, got %0d", want.duty_out, out_ch.duty_out);
          fail_count++;
        end
        if (out_ch.step_now !== want.step_now) begin
          $error("step_now: expected %0d, got %0d", want.step_now, out_ch.step_now);
          fail_count++;
        end
        if (out_ch.advanced !== want.advanced) begin
          $error("advanced: expected %0d, got %0d", want.advanced, out_ch.advanced);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: end the run if no transfer happens on any channel for too long.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_count = 0;
    end else begin
      idle_count++;
    end
    if (idle_count >= StallLimit) begin
      $display("tb_bldc_zero_cross_commutator failed");
      $finish;
    end
  end

  initial begin
    // Drive every input to a known value before reset releases.
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.z1_level   = 1'b0;
    in_ch.z2_level   = 1'b0;
    in_ch.z3_level   = 1'b0;
    in_ch.event_port = PORT_Z13;
    cfg_ch.valid     = 1'b0;
    cfg_ch.pwm_duty  = '0;
    idle_pct         = 0;
    stall_pct        = 0;
    holdoff_req      = 0;
    idle_count       = 0;
    fail_count       = 0;
    events_sent      = 0;
    results_checked  = 0;
    commutations     = 0;
    duty_writes      = 0;
    cur_step         = STEP_1;
    last_z13         = 2'b00;
    hi_pwm           = 3'b000;
    lo_on            = 3'b000;
    duty_reg         = DUTY_RESET;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed_walk();
    test_duty_extremes();
    test_random_phases();
    test_receiver_holdoff();
    wait_until_idle();

    $display("Sent %0d comparator events, checked %0d results, %0d commutations.",
             events_sent, results_checked, commutations);
    $display("Covered %0d compare value writes incl. 0 and 65535, four idling phases, %s",
             duty_writes, "and a long receiver hold-off.");
    if (fail_count == 0) begin
      $display("tb_bldc_zero_cross_commutator passed");
    end else begin
      $display("tb_bldc_zero_cross_commutator failed");
    end
    $finish;
  end

endmodule
